[rtl/cde_pkg.sv]
`timescale 1ns / 1ps

package cde_pkg;

    localparam int IDX_W   = 3;
    localparam int DATA_W  = 32;
    localparam int ORDER_W = 4;
    localparam int ACT_W   = 2;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd8;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD_F  = 2'd0,
        ACT_LOAD_P  = 2'd1,
        ACT_LOAD_Q  = 2'd2,
        ACT_COMPUTE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT
    } t_state;

    // Issue slot of the product loop plus the store write strobe.
    typedef struct packed {
        logic             wr_en;
        logic             issue;
        logic             first;
        logic             last_k;
        logic             last_elem;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] k;
    } t_cmd;

    typedef struct packed {
        logic moved;
    } t_status;

endpackage

[rtl/cde_in_if.sv]
`timescale 1ns / 1ps

interface cde_in_if;
    import cde_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACT_W-1:0]    action;
    logic [IDX_W-1:0]    row;
    logic [IDX_W-1:0]    col;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output action, output row, output col, output value,
                    input ready);
    modport sink   (input valid, input action, input row, input col, input value,
                    output ready);
endinterface

[rtl/cde_out_if.sv]
`timescale 1ns / 1ps

interface cde_out_if;
    import cde_pkg::*;

    logic                valid;
    logic                ready;
    logic [IDX_W-1:0]    out_row;
    logic [IDX_W-1:0]    out_col;
    logic signed [DATA_W-1:0] derivative;
    logic                last;

    modport source (output valid, output out_row, output out_col, output derivative,
                    output last, input ready);
    modport sink   (input valid, input out_row, input out_col, input derivative,
                    input last, output ready);
endinterface

[rtl/cde_ctrl.sv]
`timescale 1ns / 1ps

module cde_ctrl #(
    parameter int MAX_ORDER = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [cde_pkg::ORDER_W-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    input  cde_pkg::t_action         i_in_action,
    output logic                     o_in_ready,
    output cde_pkg::t_cmd            o_cmd,
    input  cde_pkg::t_status         i_status
);
    import cde_pkg::*;

    t_state             r_state, n_state;
    logic [ORDER_W-1:0] r_order;
    logic [ORDER_W-1:0] r_n, n_n;
    logic [IDX_W-1:0]   r_i, n_i;
    logic [IDX_W-1:0]   r_j, n_j;
    logic [IDX_W-1:0]   r_k, n_k;
    logic [ORDER_W-1:0] active_n;
    logic               accept;
    logic               start;
    logic               i_last, j_last, k_last, last_elem;

    always_comb begin
        if (r_order == '0) begin
            active_n = ORDER_W'(1);
        end else if (int'(r_order) > MAX_ORDER) begin
            active_n = ORDER_W'(MAX_ORDER);
        end else begin
            active_n = r_order;
        end
    end

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign start     = accept && (i_in_action == ACT_COMPUTE);
    assign i_last    = ({1'b0, r_i} == (r_n - ORDER_W'(1)));
    assign j_last    = ({1'b0, r_j} == (r_n - ORDER_W'(1)));
    assign k_last    = ({1'b0, r_k} == (r_n - ORDER_W'(1)));
    assign last_elem = i_last && j_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_order <= ORDER_RESET;
            r_n     <= ORDER_W'(1);
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_order <= i_cfg_data;
            end
            r_n <= n_n;
            r_i <= n_i;
            r_j <= n_j;
            r_k <= n_k;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (k_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_status.moved) begin
                    n_state = last_elem ? S_IDLE : S_ISSUE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Loop counters walk k inside j inside i.
    always_comb begin
        n_n = r_n;
        n_i = r_i;
        n_j = r_j;
        n_k = r_k;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_n = active_n;
                    n_i = '0;
                    n_j = '0;
                    n_k = '0;
                end
            end
            S_ISSUE: begin
                n_k = k_last ? '0 : r_k + IDX_W'(1);
            end
            S_WAIT: begin
                if (i_status.moved && !last_elem) begin
                    if (j_last) begin
                        n_j = '0;
                        n_i = r_i + IDX_W'(1);
                    end else begin
                        n_j = r_j + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_k = '0;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.wr_en      = accept && (i_in_action != ACT_COMPUTE);
        o_cmd.i          = r_i;
        o_cmd.j          = r_j;
        o_cmd.k          = r_k;
        o_cmd.first      = (r_k == '0);
        o_cmd.last_k     = k_last;
        o_cmd.last_elem  = last_elem;
        case (r_state)
            S_IDLE:  o_in_ready  = 1'b1;
            S_ISSUE: o_cmd.issue = 1'b1;
            S_WAIT:  o_in_ready  = 1'b0;
            default: o_in_ready  = 1'b0;
        endcase
    end

endmodule

[rtl/cde_datapath.sv]
`timescale 1ns / 1ps

module cde_datapath #(
    parameter int MAX_ORDER = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cde_pkg::t_cmd                     i_cmd,
    input  cde_pkg::t_action                  i_wr_action,
    input  logic [cde_pkg::IDX_W-1:0]         i_wr_row,
    input  logic [cde_pkg::IDX_W-1:0]         i_wr_col,
    input  logic signed [cde_pkg::DATA_W-1:0] i_wr_value,
    output cde_pkg::t_status                  o_status,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [cde_pkg::IDX_W-1:0]         o_out_row,
    output logic [cde_pkg::IDX_W-1:0]         o_out_col,
    output logic signed [cde_pkg::DATA_W-1:0] o_derivative,
    output logic                              o_out_last
);
    import cde_pkg::*;

    localparam int DEPTH  = MAX_ORDER * MAX_ORDER;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = PROD_W + $clog2(2 * MAX_ORDER);

    function automatic logic [AW-1:0] f_addr(input logic [IDX_W-1:0] r,
                                             input logic [IDX_W-1:0] c);
        return AW'(int'(r) * MAX_ORDER + int'(c));
    endfunction

    logic signed [DATA_W-1:0] mem_f [DEPTH];
    logic signed [DATA_W-1:0] mem_p [DEPTH];
    logic signed [DATA_W-1:0] mem_q [DEPTH];

    logic               wr_ok;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      a_ik, a_kj, a_jk, a_ij;

    // Stage 1: store reads.
    logic signed [DATA_W-1:0] r_f_ik, r_p_kj, r_p_ik, r_f_jk, r_q_ij;
    logic                     r_s1_vld, r_s1_first, r_s1_lastk, r_s1_lastel;
    logic [IDX_W-1:0]         r_s1_i, r_s1_j;
    // Stage 2: products.
    logic signed [PROD_W-1:0] r_prod0, r_prod1;
    logic signed [DATA_W-1:0] r_s2_q;
    logic                     r_s2_vld, r_s2_first, r_s2_lastk, r_s2_lastel;
    logic [IDX_W-1:0]         r_s2_i, r_s2_j;
    // Stage 3: accumulator, held until the output register takes it.
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic                     r_done;
    logic signed [DATA_W-1:0] r_h_q;
    logic [IDX_W-1:0]         r_h_i, r_h_j;
    logic                     r_h_last;
    // Output register.
    logic                     r_o_vld;
    logic [IDX_W-1:0]         r_o_row, r_o_col;
    logic signed [DATA_W-1:0] r_o_data;
    logic                     r_o_last;

    logic signed [ACC_W-1:0]  shifted;
    logic signed [ACC_W:0]    total;
    logic signed [DATA_W-1:0] sat;
    logic                     move;

    assign wr_ok   = i_cmd.wr_en && (int'(i_wr_row) < MAX_ORDER)
                     && (int'(i_wr_col) < MAX_ORDER);
    assign wr_addr = f_addr(i_wr_row, i_wr_col);
    assign a_ik    = f_addr(i_cmd.i, i_cmd.k);
    assign a_kj    = f_addr(i_cmd.k, i_cmd.j);
    assign a_jk    = f_addr(i_cmd.j, i_cmd.k);
    assign a_ij    = f_addr(i_cmd.i, i_cmd.j);

    always_ff @(posedge i_clk) begin
        if (wr_ok && (i_wr_action == ACT_LOAD_F)) begin
            mem_f[wr_addr] <= i_wr_value;
        end
        r_f_ik <= mem_f[a_ik];
        r_f_jk <= mem_f[a_jk];
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok && (i_wr_action == ACT_LOAD_P)) begin
            mem_p[wr_addr] <= i_wr_value;
        end
        r_p_kj <= mem_p[a_kj];
        r_p_ik <= mem_p[a_ik];
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok && (i_wr_action == ACT_LOAD_Q)) begin
            mem_q[wr_addr] <= i_wr_value;
        end
        r_q_ij <= mem_q[a_ij];
    end

    // The sum of all exact products is floored once at the end, which matches
    // flooring each product and carrying the dropped fractions separately.
    assign n_acc = (r_s2_first ? ACC_W'(0) : r_acc)
                   + {{(ACC_W-PROD_W){r_prod0[PROD_W-1]}}, r_prod0}
                   + {{(ACC_W-PROD_W){r_prod1[PROD_W-1]}}, r_prod1};

    assign shifted = r_acc >>> FRAC_BITS;
    assign total   = {shifted[ACC_W-1], shifted}
                     + {{(ACC_W+1-DATA_W){r_h_q[DATA_W-1]}}, r_h_q};

    always_comb begin
        if ((&total[ACC_W:DATA_W-1]) || !(|total[ACC_W:DATA_W-1])) begin
            sat = total[DATA_W-1:0];
        end else if (total[ACC_W]) begin
            sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    assign move = r_done && (!r_o_vld || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_done   <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.issue;
            r_s2_vld <= r_s1_vld;
            if (r_s2_vld && r_s2_lastk) begin
                r_done <= 1'b1;
            end else if (move) begin
                r_done <= 1'b0;
            end
            if (move) begin
                r_o_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_first  <= i_cmd.first;
        r_s1_lastk  <= i_cmd.last_k;
        r_s1_lastel <= i_cmd.last_elem;
        r_s1_i      <= i_cmd.i;
        r_s1_j      <= i_cmd.j;

        r_prod0     <= PROD_W'(r_f_ik) * PROD_W'(r_p_kj);
        r_prod1     <= PROD_W'(r_p_ik) * PROD_W'(r_f_jk);
        r_s2_q      <= r_q_ij;
        r_s2_first  <= r_s1_first;
        r_s2_lastk  <= r_s1_lastk;
        r_s2_lastel <= r_s1_lastel;
        r_s2_i      <= r_s1_i;
        r_s2_j      <= r_s1_j;

        if (r_s2_vld) begin
            r_acc <= n_acc;
        end
        if (r_s2_vld && r_s2_lastk) begin
            r_h_q    <= r_s2_q;
            r_h_i    <= r_s2_i;
            r_h_j    <= r_s2_j;
            r_h_last <= r_s2_lastel;
        end
        if (move) begin
            r_o_row  <= r_h_i;
            r_o_col  <= r_h_j;
            r_o_data <= sat;
            r_o_last <= r_h_last;
        end
    end

    assign o_status.moved = move;
    assign o_out_valid    = r_o_vld;
    assign o_out_row      = r_o_row;
    assign o_out_col      = r_o_col;
    assign o_derivative   = r_o_data;
    assign o_out_last     = r_o_last;

endmodule

[rtl/covariance_derivative_engine_top.sv]
// Load items are written to the stores on transfer and the port stays ready. A
// compute item of order n (clamped to 1..MAX_ORDER) yields n*n results; each sums
// its k terms through the dual-read F and P stores, the pair of 32x32 multipliers,
// then the accumulate and final add/saturate stages; a new result is issued once
// the previous one has moved to the output register. Reset is synchronous and
// active low; it sets the order register to 8, empties the pipeline, keeps stores.
`timescale 1ns / 1ps

module covariance_derivative_engine_top #(
    parameter int MAX_ORDER = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cde_pkg::ORDER_W-1:0]   i_cfg_data,
    cde_in_if.sink                        i_in_ch,
    cde_out_if.source                     o_out_ch
);
    import cde_pkg::*;

    t_cmd    cmd;
    t_status status;
    t_action in_action;

    assign in_action = t_action'(i_in_ch.action);

    cde_ctrl #(
        .MAX_ORDER (MAX_ORDER)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_ch.valid),
        .i_in_action (in_action),
        .o_in_ready  (i_in_ch.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    cde_datapath #(
        .MAX_ORDER (MAX_ORDER),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_wr_action  (in_action),
        .i_wr_row     (i_in_ch.row),
        .i_wr_col     (i_in_ch.col),
        .i_wr_value   (i_in_ch.value),
        .o_status     (status),
        .o_out_valid  (o_out_ch.valid),
        .i_out_ready  (o_out_ch.ready),
        .o_out_row    (o_out_ch.out_row),
        .o_out_col    (o_out_ch.out_col),
        .o_derivative (o_out_ch.derivative),
        .o_out_last   (o_out_ch.last)
    );

endmodule

[rtl/cde_checker.sv]
`timescale 1ns / 1ps

module cde_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic [cde_pkg::ACT_W-1:0]         i_in_action,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [cde_pkg::IDX_W-1:0]         i_out_row,
    input logic [cde_pkg::IDX_W-1:0]         i_out_col,
    input logic signed [cde_pkg::DATA_W-1:0] i_derivative,
    input logic                              i_out_last
);
    import cde_pkg::*;

    // A result waiting for the sink keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_derivative)
            && $stable(i_out_row) && $stable(i_out_col) && $stable(i_out_last)))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A compute transfer blocks input until its last result is latched.
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_action == ACT_COMPUTE)) |=> !i_in_ready)
        else $error("input ready right after a compute transfer");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_last) |-> !i_in_ready)
        else $error("input ready while a result matrix is incomplete");

    // The final element sits on the diagonal.
    a_last_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_last) |-> (i_out_row == i_out_col))
        else $error("last flag off the diagonal");

endmodule

bind covariance_derivative_engine_top cde_checker u_cde_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_ch.valid),
    .i_in_ready   (i_in_ch.ready),
    .i_in_action  (i_in_ch.action),
    .i_out_valid  (o_out_ch.valid),
    .i_out_ready  (o_out_ch.ready),
    .i_out_row    (o_out_ch.out_row),
    .i_out_col    (o_out_ch.out_col),
    .i_derivative (o_out_ch.derivative),
    .i_out_last   (o_out_ch.last)
);
